// File: hdl/ksl_pkg.sv
package ksl_pkg;

    // List geometry
    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 32;
    localparam int AGE_W     = 8;
    localparam int SCORE_W   = 16;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // One stored record, key in the low bits
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [AGE_W-1:0]   age;
        logic [TAG_W-1:0]   tag;
        logic [KEY_W-1:0]   key;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Operation codes carried in the input tuser
    typedef enum logic [3:0] {
        F_INSERT   = 4'd0,
        F_DEL_HEAD = 4'd1,
        F_DEL_TAIL = 4'd2,
        F_DEL_KEY  = 4'd3,
        F_LOCATE   = 4'd4,
        F_UPDATE   = 4'd5,
        F_READ     = 4'd6,
        F_PRIOR    = 4'd7,
        F_NEXT     = 4'd8
    } t_func;

    // Compare unit result
    typedef struct packed {
        logic key_eq;
        logic rec_eq;
    } t_match;

endpackage

// File: hdl/keyed_sequential_list_engine_top.sv
// Channel   Dir  Fields (tdata low bit up)                          Side info
// s_axis    in   position, key, tag, age, score, new_key,           tuser: func
//                new_tag, new_age, new_score, 3 pad bits
// m_axis    out  out_key, out_tag, out_age, out_score,              tuser: ok
//                list_length, 3 pad bits
// cfg       in   capacity (5 bits), written when i_cfg_we is high   none
//
// One word at a time: after acceptance a decode state, a pass over the entry RAM at one
// read per cycle through the registered read port, then a state that posts the result.
// Refused inserts and unknown codes skip the pass; an insert adds a write state for the
// new record. The single RAM port pair sets the pace of the pass. Reset clears count and
// control state; entries are undefined until written. A stalled result is held in the
// output register while the next word is taken.
module keyed_sequential_list_engine_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // position, key, tag, age, score, new_key, new_tag, new_age, new_score, pad
    input  logic [183:0]              s_axis_tdata,
    // func
    input  logic [3:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_key, out_tag, out_age, out_score, list_length, pad
    output logic [95:0]               m_axis_tdata,
    // ok
    output logic [0:0]                m_axis_tuser,
    input  logic                      i_cfg_we,
    input  logic [ksl_pkg::CAP_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FWD,
        S_UP,
        S_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    ksl_pkg::t_func           r_func, n_func;
    ksl_pkg::t_cnt            r_pos, n_pos;
    ksl_pkg::t_rec            r_in, n_in;
    ksl_pkg::t_rec            r_new, n_new;
    ksl_pkg::t_cnt            r_count, n_count;
    logic [ksl_pkg::CAP_W-1:0] r_cap;
    ksl_pkg::t_cnt            r_ptr, n_ptr;
    ksl_pkg::t_cnt            r_left, n_left;
    ksl_pkg::t_cnt            r_start, n_start;
    ksl_pkg::t_cnt            r_da, n_da;
    logic                     r_dv, n_dv;
    logic                     r_hit, n_hit;
    logic                     r_arm, n_arm;
    ksl_pkg::t_rec            r_res, n_res;
    ksl_pkg::t_rec            r_prev, n_prev;
    logic                     r_out_vld, n_out_vld;
    logic                     r_out_ok, n_out_ok;
    ksl_pkg::t_rec            r_out_rec, n_out_rec;
    ksl_pkg::t_cnt            r_out_len, n_out_len;

    logic                     ram_we;
    ksl_pkg::t_addr           ram_waddr;
    ksl_pkg::t_rec            ram_wdata;
    ksl_pkg::t_addr           ram_raddr;
    logic [ksl_pkg::REC_W-1:0] ram_rdata;
    ksl_pkg::t_rec            rd_rec;
    ksl_pkg::t_match          match;
    ksl_pkg::t_cnt            cap_eff;
    ksl_pkg::t_cnt            done_count;

    // Entry store and shared compare unit
    ksl_ram #(
        .WIDTH (ksl_pkg::REC_W),
        .DEPTH (ksl_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_rec = ksl_pkg::t_rec'(ram_rdata);

    ksl_cmp u_cmp (
        .i_rec   (rd_rec),
        .i_ref   (r_in),
        .o_match (match)
    );

    // Capacity above the store depth acts as the depth
    assign cap_eff = (ksl_pkg::t_cnt'(r_cap) > ksl_pkg::t_cnt'(ksl_pkg::DEPTH)) ?
                     ksl_pkg::t_cnt'(ksl_pkg::DEPTH) : ksl_pkg::t_cnt'(r_cap);

    // Length after this word completes
    always_comb begin
        done_count = r_count;
        if (r_hit) begin
            case (r_func)
                ksl_pkg::F_INSERT:   done_count = r_count + ksl_pkg::t_cnt'(1);
                ksl_pkg::F_DEL_HEAD,
                ksl_pkg::F_DEL_TAIL,
                ksl_pkg::F_DEL_KEY:  done_count = r_count - ksl_pkg::t_cnt'(1);
                default:             done_count = r_count;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // Sequencer: decode, scan or shift through the RAM, write an inserted record, post result
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_pos     = r_pos;
        n_in      = r_in;
        n_new     = r_new;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_start   = r_start;
        n_da      = r_da;
        n_dv      = 1'b0;
        n_hit     = r_hit;
        n_arm     = r_arm;
        n_res     = r_res;
        n_prev    = r_prev;
        n_out_vld = r_out_vld;
        n_out_ok  = r_out_ok;
        n_out_rec = r_out_rec;
        n_out_len = r_out_len;
        ram_we    = 1'b0;
        ram_waddr = r_da[ksl_pkg::ADDR_W-1:0];
        ram_wdata = rd_rec;
        ram_raddr = r_ptr[ksl_pkg::ADDR_W-1:0];

        // Drop the result once taken
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func      = ksl_pkg::t_func'(s_axis_tuser);
                    n_pos       = s_axis_tdata[4:0];
                    n_in.key    = s_axis_tdata[36:5];
                    n_in.tag    = s_axis_tdata[68:37];
                    n_in.age    = s_axis_tdata[76:69];
                    n_in.score  = s_axis_tdata[92:77];
                    n_new.key   = s_axis_tdata[124:93];
                    n_new.tag   = s_axis_tdata[156:125];
                    n_new.age   = s_axis_tdata[164:157];
                    n_new.score = s_axis_tdata[180:165];
                    n_state     = S_START;
                end
            end

            S_START: begin
                n_hit   = 1'b0;
                n_arm   = 1'b0;
                n_res   = r_in;
                n_ptr   = '0;
                n_start = '0;
                n_left  = r_count;
                n_state = S_FWD;
                case (r_func)
                    ksl_pkg::F_INSERT: begin
                        if (r_count < cap_eff && r_pos != '0 &&
                            r_pos <= r_count + ksl_pkg::t_cnt'(1)) begin
                            n_hit = 1'b1;
                            if (r_pos <= r_count) begin
                                n_ptr   = r_count - ksl_pkg::t_cnt'(1);
                                n_left  = r_count - r_pos + ksl_pkg::t_cnt'(1);
                                n_state = S_UP;
                            end else begin
                                n_state = S_WR;
                            end
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    ksl_pkg::F_DEL_TAIL: begin
                        n_ptr   = r_count - ksl_pkg::t_cnt'(1);
                        n_start = r_count - ksl_pkg::t_cnt'(1);
                        n_left  = (r_count != '0) ? ksl_pkg::t_cnt'(1) : '0;
                    end
                    ksl_pkg::F_READ: begin
                        n_ptr   = r_pos;
                        n_start = r_pos;
                        n_left  = (r_pos < r_count) ? ksl_pkg::t_cnt'(1) : '0;
                    end
                    ksl_pkg::F_DEL_HEAD,
                    ksl_pkg::F_DEL_KEY,
                    ksl_pkg::F_LOCATE,
                    ksl_pkg::F_UPDATE,
                    ksl_pkg::F_PRIOR,
                    ksl_pkg::F_NEXT: begin
                        n_left = r_count;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_FWD: begin
                // Issue the next read
                if (r_left != '0) begin
                    n_ptr  = r_ptr + ksl_pkg::t_cnt'(1);
                    n_left = r_left - ksl_pkg::t_cnt'(1);
                    n_dv   = 1'b1;
                    n_da   = r_ptr;
                end
                // Act on the entry that came back
                if (r_dv) begin
                    n_prev = rd_rec;
                    case (r_func)
                        ksl_pkg::F_DEL_HEAD,
                        ksl_pkg::F_DEL_KEY: begin
                            if (!r_hit && ((r_func == ksl_pkg::F_DEL_KEY) ?
                                           match.key_eq : (r_da == r_start))) begin
                                n_hit = 1'b1;
                                n_res = rd_rec;
                            end else if (r_hit) begin
                                ram_we    = 1'b1;
                                ram_waddr = ksl_pkg::t_addr'(r_da - ksl_pkg::t_cnt'(1));
                            end
                        end
                        ksl_pkg::F_DEL_TAIL,
                        ksl_pkg::F_READ: begin
                            if (!r_hit) begin
                                n_hit = 1'b1;
                                n_res = rd_rec;
                            end
                        end
                        ksl_pkg::F_LOCATE: begin
                            if (match.rec_eq) begin
                                n_hit = 1'b1;
                            end
                        end
                        ksl_pkg::F_UPDATE: begin
                            if (!r_hit && match.key_eq) begin
                                n_hit     = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = r_da[ksl_pkg::ADDR_W-1:0];
                                ram_wdata = r_new;
                            end
                        end
                        ksl_pkg::F_PRIOR: begin
                            if (!r_hit && match.key_eq && r_da != '0) begin
                                n_hit = 1'b1;
                                n_res = r_prev;
                            end
                        end
                        ksl_pkg::F_NEXT: begin
                            if (r_arm) begin
                                n_arm = 1'b0;
                                n_hit = 1'b1;
                                n_res = rd_rec;
                            end else if (!r_hit && match.key_eq &&
                                         (r_da + ksl_pkg::t_cnt'(1)) != r_count) begin
                                n_arm = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (r_left == '0 && !r_dv) begin
                    n_state = S_DONE;
                end
            end

            S_UP: begin
                // Move entries up by one, from the tail down
                if (r_left != '0) begin
                    n_ptr  = r_ptr - ksl_pkg::t_cnt'(1);
                    n_left = r_left - ksl_pkg::t_cnt'(1);
                    n_dv   = 1'b1;
                    n_da   = r_ptr;
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = ksl_pkg::t_addr'(r_da + ksl_pkg::t_cnt'(1));
                end
                if (r_left == '0 && !r_dv) begin
                    n_state = S_WR;
                end
            end

            S_WR: begin
                // Drop the new record into its slot
                ram_we    = 1'b1;
                ram_waddr = ksl_pkg::t_addr'(r_pos - ksl_pkg::t_cnt'(1));
                ram_wdata = r_in;
                n_state   = S_DONE;
            end

            S_DONE: begin
                // Post the result once the output register is free
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld = 1'b1;
                    n_out_ok  = r_hit;
                    n_out_rec = r_res;
                    n_out_len = done_count;
                    n_count   = done_count;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cap     <= ksl_pkg::CAP_W'(ksl_pkg::CAP_RESET);
            r_dv      <= 1'b0;
            r_hit     <= 1'b0;
            r_arm     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_hit     <= n_hit;
            r_arm     <= n_arm;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
        r_func    <= n_func;
        r_pos     <= n_pos;
        r_in      <= n_in;
        r_new     <= n_new;
        r_ptr     <= n_ptr;
        r_left    <= n_left;
        r_start   <= n_start;
        r_da      <= n_da;
        r_res     <= n_res;
        r_prev    <= n_prev;
        r_out_ok  <= n_out_ok;
        r_out_rec <= n_out_rec;
        r_out_len <= n_out_len;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {3'b000, r_out_len, r_out_rec};

    // Length never exceeds the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ksl_pkg::t_cnt'(ksl_pkg::DEPTH))
        else $error("list length beyond depth");

    // Length changes only when a result is posted
    a_count_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state) == S_DONE)
        else $error("list length changed outside result post");

    // A posted result carries the new length
    a_len_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_vld || m_axis_tready)) |=>
        (r_out_vld && r_out_len == r_count))
        else $error("posted length differs from list length");

    // RAM writes happen only in pass or write states
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FWD || r_state == S_UP || r_state == S_WR))
        else $error("RAM write outside a pass");

    // A successful insert is only taken while the store has room
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_func == ksl_pkg::F_INSERT && r_hit) |->
        r_count < ksl_pkg::t_cnt'(ksl_pkg::DEPTH))
        else $error("insert accepted into a full store");

endmodule

// File: hdl/ksl_ram.sv
module ksl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ksl_cmp.sv
module ksl_cmp (
    input  ksl_pkg::t_rec   i_rec,
    input  ksl_pkg::t_rec   i_ref,
    output ksl_pkg::t_match o_match
);

    // Compare the entry just read against the item record
    always_comb begin
        o_match.key_eq = (i_rec.key == i_ref.key);
        o_match.rec_eq = (i_rec.key == i_ref.key) && (i_rec.tag == i_ref.tag) &&
                         (i_rec.age == i_ref.age) && (i_rec.score == i_ref.score);
    end

endmodule
